// File: rtl/dtq_pkg.sv
package dtq_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int SLOT_W = $clog2(NUM_TIMERS);
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam int MAX_RESULTS = 16;
   localparam int FIRE_W = $clog2(MAX_RESULTS + 1);

   localparam logic [47:0] DEADLINE_MAX = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_TICK   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_ADDED    = 3'd0,
      KIND_FULL     = 3'd1,
      KIND_REMOVED  = 3'd2,
      KIND_NOTFOUND = 3'd3,
      KIND_FIRED    = 3'd4,
      KIND_NONE_DUE = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ACT,
      ST_MIN,
      ST_RESP
   } state_type;

endpackage

// File: rtl/deadline_timer_queue.sv
// an add runs the min scan before its result; a remove or the first result of a tick
// comes after the search pass, the act step and the min scan
// each further fire of a tick repeats the search, act and min scan after the previous result is taken
// one request at a time, as the one read port of the slot memory is swept once
// per search pass; the next request is taken once the last result is taken and the queue is idle
// reset: synchronous, active high; clears valid bits, id counter and control, not the slots
module deadline_timer_queue
   import dtq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [47:0] req_deadline_ms,
   input  logic [31:0] req_period_ms,
   input  logic [31:0] req_target_id,
   input  logic [47:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_timer_id,
   output logic        rsp_rescheduled,
   output logic [47:0] rsp_next_deadline_ms,
   output logic [31:0] rsp_next_period_ms,
   output logic        rsp_last
);

   // slot memory: id, deadline, period packed in one word
   localparam int ENT_W = 32 + 48 + 32;
   logic [ENT_W-1:0] mem [NUM_TIMERS];
   logic [ENT_W-1:0] rd_data_ff;
   logic             mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [ENT_W-1:0] mem_wdata;
   logic [SLOT_W-1:0] mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   // control state
   state_type state_ff, state_in;
   logic [NUM_TIMERS-1:0] valid_ff, valid_in;
   logic [NUM_TIMERS-1:0] fired_ff, fired_in;
   logic [31:0] id_cnt_ff, id_cnt_in;
   op_type      op_ff, op_in;
   logic [47:0] dl_ff, dl_in;
   logic [31:0] per_ff, per_in;
   logic [31:0] tid_ff, tid_in;
   logic [47:0] now_ff, now_in;
   // sweep: issue counter and slot index registered alongside the read data
   logic [CNT_W-1:0] rcnt_ff, rcnt_in;
   logic             rv_ff, rv_in;
   logic [SLOT_W-1:0] rslot_ff, rslot_in;
   // best candidate of the sweep
   logic             bfound_ff, bfound_in;
   logic [SLOT_W-1:0] bslot_ff, bslot_in;
   logic [ENT_W-1:0] bent_ff, bent_in;
   logic [FIRE_W-1:0] nfire_ff, nfire_in;
   // another unfired timer still due, seen during the min scan of a tick
   logic             more_ff, more_in;
   // pending result
   logic [2:0]  kind_ff, kind_in;
   logic [31:0] rid_ff, rid_in;
   logic        resch_ff, resch_in;
   logic        rlast_ff, rlast_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] ndl_ff, ndl_in;
   logic [31:0] nper_ff, nper_in;

   logic [SLOT_W-1:0] free_slot;
   logic              have_free;
   logic [31:0] e_id;
   logic [47:0] e_dl;
   logic [31:0] e_per;
   logic        e_cand;
   logic        e_better;
   logic [48:0] resched_sum;
   logic [47:0] resched_dl;
   logic        sweep_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         id_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         id_cnt_ff    <= id_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rv_ff        <= rv_in;
      end
      fired_ff  <= fired_in;
      op_ff     <= op_in;
      dl_ff     <= dl_in;
      per_ff    <= per_in;
      tid_ff    <= tid_in;
      now_ff    <= now_in;
      rcnt_ff   <= rcnt_in;
      rslot_ff  <= rslot_in;
      bfound_ff <= bfound_in;
      bslot_ff  <= bslot_in;
      bent_ff   <= bent_in;
      nfire_ff  <= nfire_in;
      more_ff   <= more_in;
      kind_ff   <= kind_in;
      rid_ff    <= rid_in;
      resch_ff  <= resch_in;
      rlast_ff  <= rlast_in;
      ndl_ff    <= ndl_in;
      nper_ff   <= nper_in;
   end

   // lowest free slot from the valid bits
   always_comb begin
      free_slot = '0;
      have_free = 1'b0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SLOT_W'(i);
            have_free = 1'b1;
         end
      end
   end

   // entry returned by the sweep read
   assign e_id  = rd_data_ff[ENT_W-1 -: 32];
   assign e_dl  = rd_data_ff[79:32];
   assign e_per = rd_data_ff[31:0];

   // candidate filter per pass type
   always_comb begin
      unique case (state_ff)
         ST_SCAN: begin
            if (op_ff == OP_REMOVE) begin
               e_cand = valid_ff[rslot_ff] && (e_id == tid_ff);
            end else begin
               e_cand = valid_ff[rslot_ff] && !fired_ff[rslot_ff] && (e_dl <= now_ff);
            end
         end
         default: e_cand = valid_ff[rslot_ff];
      endcase
   end

   // (deadline, id) order; sweep goes up so ties keep the lower slot
   always_comb begin
      if (!bfound_ff) begin
         e_better = 1'b1;
      end else if (e_dl != bent_ff[79:32]) begin
         e_better = e_dl < bent_ff[79:32];
      end else begin
         e_better = e_id < bent_ff[ENT_W-1 -: 32];
      end
   end

   assign resched_sum = {1'b0, now_ff} + {17'd0, bent_ff[31:0]};
   assign resched_dl  = resched_sum[48] ? DEADLINE_MAX : resched_sum[47:0];
   assign sweep_done  = rv_ff && (rslot_ff == SLOT_W'(NUM_TIMERS - 1));
   assign req_ready   = (state_ff == ST_IDLE) && !rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready && op_type'(req_operation) != OP_NONE) begin
               state_in = (op_type'(req_operation) == OP_ADD) ? ST_MIN : ST_SCAN;
            end
         end
         ST_SCAN: if (sweep_done) state_in = ST_ACT;
         ST_ACT:  state_in = ST_MIN;
         ST_MIN:  if (sweep_done) state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_valid_ff) begin
               state_in = (op_ff == OP_TICK && !rlast_ff) ? ST_SCAN : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      valid_in     = valid_ff;
      fired_in     = fired_ff;
      id_cnt_in    = id_cnt_ff;
      op_in        = op_ff;
      dl_in        = dl_ff;
      per_in       = per_ff;
      tid_in       = tid_ff;
      now_in       = now_ff;
      rcnt_in      = rcnt_ff;
      rv_in        = 1'b0;
      rslot_in     = rslot_ff;
      bfound_in    = bfound_ff;
      bslot_in     = bslot_ff;
      bent_in      = bent_ff;
      nfire_in     = nfire_ff;
      more_in      = more_ff;
      kind_in      = kind_ff;
      rid_in       = rid_ff;
      resch_in     = resch_ff;
      rlast_in     = rlast_ff;
      ndl_in       = ndl_ff;
      nper_in      = nper_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we       = 1'b0;
      mem_waddr    = bslot_ff;
      mem_wdata    = bent_ff;
      mem_raddr    = rcnt_ff[SLOT_W-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // sweep read issue, one slot a cycle
      if ((state_ff == ST_SCAN || state_ff == ST_MIN) && rcnt_ff < CNT_W'(NUM_TIMERS)) begin
         rv_in    = 1'b1;
         rslot_in = rcnt_ff[SLOT_W-1:0];
         rcnt_in  = rcnt_ff + CNT_W'(1);
      end
      if ((state_ff == ST_SCAN || state_ff == ST_MIN) && rv_ff && e_cand) begin
         if (state_ff == ST_MIN || op_ff == OP_TICK) begin
            if (e_better) begin
               bfound_in = 1'b1;
               bslot_in  = rslot_ff;
               bent_in   = rd_data_ff;
            end
         end else if (!bfound_ff) begin
            // remove: first matching slot
            bfound_in = 1'b1;
            bslot_in  = rslot_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            rcnt_in   = '0;
            bfound_in = 1'b0;
            nfire_in  = '0;
            fired_in  = '0;
            more_in   = 1'b0;
            if (req_valid && req_ready) begin
               op_in  = op_type'(req_operation);
               dl_in  = req_deadline_ms;
               per_in = req_period_ms;
               tid_in = req_target_id;
               now_in = req_now_ms;
               if (op_type'(req_operation) == OP_ADD) begin
                  rlast_in = 1'b1;
                  resch_in = 1'b0;
                  if (have_free) begin
                     id_cnt_in           = id_cnt_ff + 32'd1;
                     valid_in[free_slot] = 1'b1;
                     mem_we              = 1'b1;
                     mem_waddr           = free_slot;
                     mem_wdata           = {id_cnt_ff + 32'd1, req_deadline_ms,
                                            req_period_ms};
                     kind_in             = KIND_ADDED;
                     rid_in              = id_cnt_ff + 32'd1;
                  end else begin
                     kind_in = KIND_FULL;
                     rid_in  = '0;
                  end
               end
            end
         end
         ST_SCAN: ;
         ST_ACT: begin
            rcnt_in   = '0;
            bfound_in = 1'b0;
            more_in   = 1'b0;
            resch_in  = 1'b0;
            rlast_in  = 1'b1;
            if (op_ff == OP_REMOVE) begin
               if (bfound_ff) begin
                  valid_in[bslot_ff] = 1'b0;
                  kind_in            = KIND_REMOVED;
                  rid_in             = tid_ff;
               end else begin
                  kind_in = KIND_NOTFOUND;
                  rid_in  = '0;
               end
            end else if (bfound_ff) begin
               fired_in[bslot_ff] = 1'b1;
               nfire_in           = nfire_ff + FIRE_W'(1);
               kind_in            = KIND_FIRED;
               rid_in             = bent_ff[ENT_W-1 -: 32];
               // last at the result limit, else the min scan decides
               rlast_in = (nfire_ff + FIRE_W'(1) == FIRE_W'(MAX_RESULTS));
               if (bent_ff[31:0] != 32'd0) begin
                  resch_in  = 1'b1;
                  mem_we    = 1'b1;
                  mem_waddr = bslot_ff;
                  mem_wdata = {bent_ff[ENT_W-1 -: 32], resched_dl, bent_ff[31:0]};
               end else begin
                  valid_in[bslot_ff] = 1'b0;
               end
            end else begin
               kind_in = KIND_NONE_DUE;
               rid_in  = '0;
            end
         end
         ST_MIN: begin
            // any unfired timer still due means the tick goes on
            if (rv_ff && valid_ff[rslot_ff] && !fired_ff[rslot_ff] && (e_dl <= now_ff)) begin
               more_in = 1'b1;
            end
            if (sweep_done) begin
               ndl_in = (bfound_in) ? bent_in[79:32] : 48'd0;
               nper_in = (bfound_in) ? bent_in[31:0] : 32'd0;
               if (kind_ff == KIND_FIRED && !more_in) begin
                  rlast_in = 1'b1;
               end
               rsp_valid_in = 1'b1;
            end
         end
         ST_RESP: begin
            rcnt_in   = '0;
            bfound_in = 1'b0;
         end
         default: ;
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = kind_ff;
   assign rsp_timer_id         = rid_ff;
   assign rsp_rescheduled      = resch_ff;
   assign rsp_next_deadline_ms = ndl_ff;
   assign rsp_next_period_ms   = nper_ff;
   assign rsp_last             = rlast_ff;

endmodule
